>>> rtl/i2cmbs_pkg.sv
// i2cmbs_pkg: operation codes, phase codes, constants and the result beat type
// for the i2c master bit sequencer. No dependencies.
`default_nettype none
package i2cmbs_pkg;

	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_STOP    = 3'd1;
	localparam logic [2:0] OP_SEND    = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_WAITACK = 3'd4;
	localparam logic [2:0] OP_ACK     = 3'd5;
	localparam logic [2:0] OP_NACK    = 3'd6;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ONE  = 2'd1;
	localparam logic [1:0] PH_TWO  = 2'd2;
	localparam logic [1:0] PH_THREE = 2'd3;

	localparam int unsigned DELAY_W = 16;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5;
	localparam logic [2:0] LAST_BIT = 3'd7;
	localparam int unsigned MSB_IDX = 7;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       ack;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/i2c_master_bit_sequencer.sv
// i2c_master_bit_sequencer: top level, open-drain i2c bus phase sequencer.
// Depends on i2cmbs_pkg for operation codes, phase codes and the result type.
//
// Each input beat is one bus tick and produces exactly one result beat. A beat is
// taken every cycle while in_ready is high: the bus state steps on the accepting
// edge and its result is registered. A two-entry output buffer (result register plus
// skid register) lets the block take one more beat while a result waits; in_ready
// drops only when both entries are full. Commands are started from idle only; each
// phase holds delay_q ticks, as written through cfg_wr_data (zero counts as one).
`default_nettype none
module i2c_master_bit_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd_valid,
	input  wire logic [2:0]  operation,
	input  wire logic [7:0]  tx_byte,
	input  wire logic        sda_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             scl_out,
	output logic             sda_out,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       rx_byte,
	output logic             ack_bit
);
	import i2cmbs_pkg::*;

	logic [DELAY_W-1:0] delay_q;
	logic [1:0]         phase_q, phase_n;
	logic [2:0]         op_q, op_n;
	logic [2:0]         bc_q, bc_n;
	logic [DELAY_W-1:0] wc_q, wc_n, wc_dec;
	logic [7:0]         txs_q, txs_n;
	logic [7:0]         rxs_q, rxs_n;
	logic               ack_q, ack_n;
	logic               scl_q, scl_n;
	logic               sda_q, sda_n;
	logic               done_n;
	logic               enter;
	logic [1:0]         step;
	logic [DELAY_W-1:0] delay_eff;
	logic               accept;
	res_t               res_n, a_q, b_q;
	logic               a_valid_q, b_valid_q;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !b_valid_q;
	assign delay_eff = (delay_q == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : delay_q;
	assign wc_dec    = (wc_q != '0) ? wc_q - {{(DELAY_W-1){1'b0}}, 1'b1} : wc_q;

	// next bus state for one tick
	always_comb begin
		phase_n = phase_q;
		op_n    = op_q;
		bc_n    = bc_q;
		wc_n    = wc_q;
		txs_n   = txs_q;
		rxs_n   = rxs_q;
		ack_n   = ack_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		done_n  = 1'b0;
		enter   = 1'b0;
		step    = PH_ONE;

		if (phase_q != PH_IDLE) begin
			wc_n = wc_dec;
			if (wc_dec == '0) begin
				priority if (op_q == OP_STOP) begin
					sda_n  = 1'b1;
					done_n = 1'b1;
				end else if (op_q == OP_SEND || op_q == OP_READ) begin
					priority if (phase_q < ((op_q == OP_SEND) ? PH_THREE : PH_TWO)) begin
						enter = 1'b1;
						step  = phase_q + 2'd1;
					end else if (bc_q == LAST_BIT) begin
						done_n = 1'b1;
					end else begin
						bc_n  = bc_q + 3'd1;
						enter = 1'b1;
						step  = PH_ONE;
					end
				end else begin
					priority if (phase_q < PH_THREE) begin
						enter = 1'b1;
						step  = phase_q + 2'd1;
					end else begin
						if (op_q == OP_ACK) sda_n = 1'b1;
						done_n = 1'b1;
					end
				end
			end
		end else if (cmd_valid && operation <= OP_NACK) begin
			op_n  = operation;
			bc_n  = '0;
			txs_n = tx_byte;
			enter = 1'b1;
			step  = PH_ONE;
		end

		if (enter) begin
			phase_n = step;
			wc_n    = delay_eff;
			unique case (op_n)
				OP_START: begin
					unique case (step)
						PH_ONE: begin
							scl_n = 1'b1;
							sda_n = 1'b1;
						end
						PH_TWO:  sda_n = 1'b0;
						default: scl_n = 1'b0;
					endcase
				end
				OP_STOP: begin
					sda_n = 1'b0;
					scl_n = 1'b1;
				end
				OP_SEND: begin
					unique case (step)
						PH_ONE:  sda_n = txs_n[MSB_IDX];
						PH_TWO:  scl_n = 1'b1;
						default: begin
							scl_n = 1'b0;
							if (bc_n == LAST_BIT) sda_n = 1'b1;
							txs_n = {txs_n[6:0], 1'b0};
						end
					endcase
				end
				OP_READ: begin
					if (step == PH_ONE) begin
						sda_n = 1'b1;
						scl_n = 1'b1;
						rxs_n = {rxs_q[6:0], 1'b0};
					end else begin
						rxs_n = {rxs_q[7:1], rxs_q[0] | sda_in};
						scl_n = 1'b0;
					end
				end
				OP_WAITACK: begin
					unique case (step)
						PH_ONE:  scl_n = 1'b1;
						PH_TWO:  sda_n = 1'b1;
						default: begin
							ack_n = sda_in;
							scl_n = 1'b0;
						end
					endcase
				end
				default: begin
					unique case (step)
						PH_ONE:  sda_n = (op_n != OP_ACK);
						PH_TWO:  scl_n = 1'b1;
						default: scl_n = 1'b0;
					endcase
				end
			endcase
		end

		if (done_n) begin
			phase_n = PH_IDLE;
			bc_n    = '0;
		end

		res_n.scl  = scl_n;
		res_n.sda  = sda_n;
		res_n.busy = (phase_n != PH_IDLE);
		res_n.done = done_n;
		res_n.rx   = rxs_n;
		res_n.ack  = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_wr_en) begin
			delay_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= OP_START;
			bc_q    <= '0;
			wc_q    <= '0;
			txs_q   <= '0;
			rxs_q   <= '0;
			ack_q   <= 1'b1;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_n;
			op_q    <= op_n;
			bc_q    <= bc_n;
			wc_q    <= wc_n;
			txs_q   <= txs_n;
			rxs_q   <= rxs_n;
			ack_q   <= ack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

	// result register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else begin
			if (!a_valid_q || out_ready) begin
				if (b_valid_q) begin
					a_valid_q <= 1'b1;
					b_valid_q <= 1'b0;
				end else begin
					a_valid_q <= accept;
				end
			end else if (accept) begin
				b_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!a_valid_q || out_ready) begin
			a_q <= b_valid_q ? b_q : res_n;
		end else if (accept) begin
			b_q <= res_n;
		end
	end

	assign out_valid = a_valid_q;
	assign scl_out   = a_q.scl;
	assign sda_out   = a_q.sda;
	assign busy_res  = a_q.busy;
	assign done_res  = a_q.done;
	assign rx_byte   = a_q.rx;
	assign ack_bit   = a_q.ack;

	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid_q |-> a_valid_q)
		else $error("skid entry held without a result entry");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(a_valid_q && a_q.done) |-> !a_q.busy)
		else $error("done beat reports busy");

	a_busy_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (wc_q != '0))
		else $error("running phase with empty wait count");

	a_bitcount_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (bc_q == '0))
		else $error("bit count not cleared while idle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(a_valid_q && !out_ready) |=> a_valid_q)
		else $error("stalled result dropped");

endmodule
`default_nettype wire
